// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the CRC-32 unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside of reset.
`define CRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define CRC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CRC_ASSERT(label, clk, rst, prop, msg)

`define CRC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/crc32cr_pkg.sv =====
// Package with the constants, register indexes and CRC functions of the CRC-32 unit.
package crc32cr_pkg;

   localparam int DATA_W      = 8;
   localparam int CRC_W       = 32;
   localparam int CSR_INDEX_W = 8;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INITIAL_VALUE  = 8'd0,
      CSR_REFLECT_INPUT  = 8'd1,
      CSR_REFLECT_OUTPUT = 8'd2,
      CSR_INVERT_OUTPUT  = 8'd3
   } csr_index_type;

   // Reverses the bit order of one byte by swapping nibbles, pairs and bits.
   function automatic logic [DATA_W-1:0] rev8(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] t;
      t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
      t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
      t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
      return t;
   endfunction

   function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
      return {rev8(v[7:0]), rev8(v[15:8]), rev8(v[23:16]), rev8(v[31:24])};
   endfunction

   // Folds one byte into the top of the register, MSB first, eight shift/XOR steps.
   function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, {(CRC_W-DATA_W){1'b0}}};
      for (int k = 0; k < DATA_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/crc32cr_channels.sv =====
// Handshake channel interfaces for byte input, checksum output and register writes.
interface crc32cr_req_if;
   import crc32cr_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              byte_present;
   logic              last_item;

   modport source (output valid, data_byte, byte_present, last_item, input ready);
   modport sink   (input valid, data_byte, byte_present, last_item, output ready);
endinterface

interface crc32cr_rsp_if;
   import crc32cr_pkg::*;

   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] crc_result;

   modport source (output valid, crc_result, input ready);
   modport sink   (input valid, crc_result, output ready);
endinterface

interface crc32cr_csr_if;
   import crc32cr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CRC_W-1:0]       wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hdl/crc32_configurable_reflect_unit.sv =====
// Top level of the configurable byte-serial CRC-32 unit.
// This unit computes a CRC-32 over polynomial 0x04C11DB7, at most one message byte per beat, with
// the initial value, input byte reflection, output reflection and output inversion set
// through the register port (reset values give the standard Ethernet CRC-32). It takes one
// beat per clock cycle while the input is not stalled: a beat is captured in an input
// register, then folded through an eight-step XOR network into the running register, and
// a beat marked last leaves its checksum in the output register. Input and output stalls
// are absorbed by those two registers; the input stalls only while a finished checksum is
// still waiting and another last beat is queued.
// Registers should be written only while no beat is in flight.
`include "assert_macros.svh"

module crc32_configurable_reflect_unit (
   input logic          clock,
   input logic          reset,
   crc32cr_req_if.sink  req_bus,
   crc32cr_rsp_if.source rsp_bus,
   crc32cr_csr_if.sink  csr_bus
);
   import crc32cr_pkg::*;

   // Configuration registers.
   logic [CRC_W-1:0]  init_value_ff, init_value_in;
   logic              refl_in_ff, refl_in_in;
   logic              refl_out_ff, refl_out_in;
   logic              invert_ff, invert_in;

   // Input stage.
   logic              stg_valid_ff, stg_valid_in;
   logic [DATA_W-1:0] stg_byte_ff, stg_byte_in;
   logic              stg_present_ff, stg_present_in;
   logic              stg_last_ff, stg_last_in;

   // Running state.
   logic [CRC_W-1:0]  running_crc_ff, running_crc_in;
   logic              in_message_ff, in_message_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]  rsp_crc_ff, rsp_crc_in;

   logic              req_take;
   logic              rsp_take;
   logic              csr_take;
   logic              stg_fire;
   logic [DATA_W-1:0] byte_sel;
   logic [CRC_W-1:0]  base_crc;
   logic [CRC_W-1:0]  folded_crc;
   logic [CRC_W-1:0]  msg_crc;
   logic [CRC_W-1:0]  refl_crc;
   logic [CRC_W-1:0]  final_crc;

   assign csr_bus.ready      = 1'b1;
   assign csr_take           = csr_bus.valid & csr_bus.ready;
   assign rsp_take           = rsp_valid_ff & rsp_bus.ready;

   // A last beat needs the output register free, or freed in this cycle.
   assign stg_fire           = stg_valid_ff & (~stg_last_ff | ~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready      = ~stg_valid_ff | stg_fire;
   assign req_take           = req_bus.valid & req_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.crc_result = rsp_crc_ff;

   // Fold datapath: the first byte of a message starts from the initial value.
   always_comb begin
      byte_sel   = refl_in_ff ? rev8(stg_byte_ff) : stg_byte_ff;
      base_crc   = in_message_ff ? running_crc_ff : init_value_ff;
      folded_crc = fold_byte(base_crc, byte_sel);
      msg_crc    = stg_present_ff ? folded_crc : base_crc;
      refl_crc   = refl_out_ff ? rev32(msg_crc) : msg_crc;
      final_crc  = invert_ff ? (refl_crc ^ CRC_ONES) : refl_crc;
   end

   always_comb begin
      init_value_in = init_value_ff;
      refl_in_in    = refl_in_ff;
      refl_out_in   = refl_out_ff;
      invert_in     = invert_ff;
      if (csr_take) begin
         case (csr_bus.index)
            CSR_INITIAL_VALUE:  init_value_in = csr_bus.wdata;
            CSR_REFLECT_INPUT:  refl_in_in    = csr_bus.wdata[0];
            CSR_REFLECT_OUTPUT: refl_out_in   = csr_bus.wdata[0];
            CSR_INVERT_OUTPUT:  invert_in     = csr_bus.wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      stg_valid_in   = stg_valid_ff;
      stg_byte_in    = stg_byte_ff;
      stg_present_in = stg_present_ff;
      stg_last_in    = stg_last_ff;
      if (req_take) begin
         stg_valid_in   = 1'b1;
         stg_byte_in    = req_bus.data_byte;
         stg_present_in = req_bus.byte_present;
         stg_last_in    = req_bus.last_item;
      end else if (stg_fire) begin
         stg_valid_in = 1'b0;
      end
   end

   always_comb begin
      running_crc_in = running_crc_ff;
      in_message_in  = in_message_ff;
      if (stg_fire) begin
         if (stg_last_ff) begin
            running_crc_in = init_value_ff;
            in_message_in  = 1'b0;
         end else if (stg_present_ff) begin
            running_crc_in = folded_crc;
            in_message_in  = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in   = rsp_crc_ff;
      if (stg_fire && stg_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = final_crc;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_value_ff  <= CRC_ONES;
         refl_in_ff     <= 1'b1;
         refl_out_ff    <= 1'b1;
         invert_ff      <= 1'b1;
         stg_valid_ff   <= 1'b0;
         in_message_ff  <= 1'b0;
         running_crc_ff <= CRC_ONES;
         rsp_valid_ff   <= 1'b0;
      end else begin
         init_value_ff  <= init_value_in;
         refl_in_ff     <= refl_in_in;
         refl_out_ff    <= refl_out_in;
         invert_ff      <= invert_in;
         stg_valid_ff   <= stg_valid_in;
         in_message_ff  <= in_message_in;
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_byte_ff    <= stg_byte_in;
      stg_present_ff <= stg_present_in;
      stg_last_ff    <= stg_last_in;
      rsp_crc_ff     <= rsp_crc_in;
   end

   // A finished last beat always leaves a checksum waiting in the output register.
   `CRC_ASSERT(a_last_gives_result, clock, reset,
      (stg_fire && stg_last_ff) |=> rsp_valid_ff,
      "last beat did not produce a result")
   // After a message ends, the next byte starts again from the initial value.
   `CRC_ASSERT(a_last_ends_message, clock, reset,
      (stg_fire && stg_last_ff) |=> !in_message_ff,
      "message still open after last beat")
   // A waiting checksum is never overwritten before it is taken.
   `CRC_ASSERT(a_result_kept, clock, reset,
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_crc_ff)),
      "pending result lost or changed")
   // A staged beat that cannot move on stays in the input register.
   `CRC_ASSERT(a_stage_held, clock, reset,
      (stg_valid_ff && !stg_fire) |=> (stg_valid_ff && $stable(stg_last_ff)),
      "stalled beat dropped")
   // The input is refused only while a last beat waits on a full output register.
   `CRC_ASSERT_ALWAYS(a_ready_rule, clock,
      (!req_bus.ready) |-> (stg_valid_ff && stg_last_ff && rsp_valid_ff),
      "input stalled without cause")

endmodule
